// ===== src/ngga_pkg.sv =====
package ngga_pkg;

  // longest line kept; a further non-terminator byte drops the line
  localparam int unsigned MaxLine = 80;
  localparam int unsigned LenW    = 7;

  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChG      = 8'h47;
  localparam logic [7:0] ChA      = 8'h41;
  localparam logic [7:0] ChS      = 8'h53;
  localparam logic [7:0] ChW      = 8'h57;

  // field numbers (comma counts) of interest
  localparam logic [3:0] FldLat   = 4'd2;
  localparam logic [3:0] FldNs    = 4'd3;
  localparam logic [3:0] FldLon   = 4'd4;
  localparam logic [3:0] FldEw    = 4'd5;
  localparam logic [3:0] FldFix   = 4'd6;
  localparam logic [3:0] FldDop   = 4'd8;
  localparam logic [3:0] CommaMax = 4'd9;

  // slots of the running field values
  localparam logic [1:0] SlotLat = 2'd0;
  localparam logic [1:0] SlotLon = 2'd1;
  localparam logic [1:0] SlotFix = 2'd2;
  localparam logic [1:0] SlotDop = 2'd3;

  localparam logic [31:0] SignBit = 32'h8000_0000;
  localparam logic [31:0] NoFix   = 32'h7fff_ffff;
  localparam logic [7:0]  DopMax  = 8'hff;

  // hex value of a character, zero for anything else
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        t = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        t = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
        t = c - 8'h37;
      end
      return t[3:0];
    end
  endfunction

endpackage

// ===== src/nmea_gga_sentence_parser.sv =====
// channel | valid      | ready      | payload
// rx      | rx_valid_i | rx_ready_o | rx_byte_i
// result  | res_valid_o| res_ready_i| sentence_taken_o fix_valid_o latitude_o
//         |            |            | longitude_o dilution_o
// one byte is taken per cycle while rx_ready_o is high; all per-line state updates in that cycle
// a CR/LF ending a nonempty line loads the result register, shown the next cycle
// rx stalls only while a result waits in the output register and is not taken
// asynchronous active-low reset clears the line state and the result valid
module nmea_gga_sentence_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        sentence_taken_o,
  output logic        fix_valid_o,
  output logic [31:0] latitude_o,
  output logic [31:0] longitude_o,
  output logic [7:0]  dilution_o
);

  localparam int unsigned LenW = ngga_pkg::LenW;

  // line state
  logic [LenW-1:0] len_q, len_d;
  logic            start_ok_q, start_ok_d;
  logic            type_ok_q, type_ok_d;
  logic [7:0]      xor_q, xor_d;
  logic            star_q, star_d;
  logic [LenW-1:0] star_pos_q, star_pos_d;
  logic [15:0]     last2_q, last2_d;
  logic [3:0]      commas_q, commas_d;
  logic            fstart_q, fstart_d;
  logic [31:0]     fv_q [4];
  logic [31:0]     fv_d [4];
  logic [1:0]      hemi_q, hemi_d;

  // result register
  logic        res_valid_q, res_valid_d;
  logic        taken_q, taken_d;
  logic        fix_q, fix_d;
  logic [31:0] lat_q, lat_d;
  logic [31:0] lon_q, lon_d;
  logic [7:0]  dop_q, dop_d;

  logic        accept;
  logic        eol;
  logic        emit;
  logic        clear;
  logic [7:0]  b;
  logic [7:0]  check;
  logic [7:0]  star_end;
  logic        taken;
  logic        valid;
  logic        slot_hit;
  logic [1:0]  slot;
  logic [31:0] slot_val;
  logic [31:0] slot_new;

  // output register frees in the same cycle it is drained
  assign rx_ready_o = !res_valid_q || res_ready_i;
  assign accept     = rx_valid_i && rx_ready_o;
  assign b          = rx_byte_i;
  assign eol        = (b == ngga_pkg::ChCr) || (b == ngga_pkg::ChLf);
  assign emit       = accept && eol && (len_q != '0);
  // a nonempty line ends, or an overlong line is dropped
  assign clear      = emit || (accept && !eol &&
                      ({1'b0, len_q} >= (LenW+1)'(ngga_pkg::MaxLine)));

  // end-of-line checks
  assign check    = {ngga_pkg::hex_value(last2_q[15:8]), ngga_pkg::hex_value(last2_q[7:0])};
  assign star_end = {1'b0, star_pos_q} + 8'd3;
  assign taken    = start_ok_q && type_ok_q && (len_q >= LenW'(6)) && star_q
                    && (star_end == 8'(len_q)) && (check == xor_q);
  assign valid    = taken && (fv_q[ngga_pkg::SlotFix] == 32'd1);

  // which running field a digit feeds
  always_comb begin
    slot_hit = 1'b1;
    slot     = ngga_pkg::SlotLat;
    unique case (commas_q)
      ngga_pkg::FldLat: slot = ngga_pkg::SlotLat;
      ngga_pkg::FldLon: slot = ngga_pkg::SlotLon;
      ngga_pkg::FldFix: slot = ngga_pkg::SlotFix;
      ngga_pkg::FldDop: slot = ngga_pkg::SlotDop;
      default:          slot_hit = 1'b0;
    endcase
  end

  // value*10 + digit, wrapping at 32 bits
  assign slot_val = fv_q[slot];
  assign slot_new = (slot_val << 3) + (slot_val << 1)
                    + {28'd0, ngga_pkg::hex_value(b)};

  // line state next value
  always_comb begin
    len_d      = len_q;
    start_ok_d = start_ok_q;
    type_ok_d  = type_ok_q;
    xor_d      = xor_q;
    star_d     = star_q;
    star_pos_d = star_pos_q;
    last2_d    = last2_q;
    commas_d   = commas_q;
    fstart_d   = fstart_q;
    fv_d       = fv_q;
    hemi_d     = hemi_q;

    if (clear) begin
      len_d      = '0;
      start_ok_d = 1'b0;
      type_ok_d  = 1'b0;
      xor_d      = '0;
      star_d     = 1'b0;
      star_pos_d = '0;
      last2_d    = '0;
      commas_d   = '0;
      fstart_d   = 1'b0;
      for (int i = 0; i < 4; i++) begin
        fv_d[i] = '0;
      end
      hemi_d     = '0;
    end else if (accept && !eol) begin
      if (len_q == LenW'(0)) start_ok_d = (b == ngga_pkg::ChDollar);
      if (len_q == LenW'(3)) type_ok_d  = (b == ngga_pkg::ChG);
      if (len_q == LenW'(4)) type_ok_d  = type_ok_q && (b == ngga_pkg::ChG);
      if (len_q == LenW'(5)) type_ok_d  = type_ok_q && (b == ngga_pkg::ChA);

      // checksum covers bytes after '$' up to the first star
      if ((len_q != '0) && !star_q) begin
        if (b == ngga_pkg::ChStar) begin
          star_d     = 1'b1;
          star_pos_d = len_q;
        end else begin
          xor_d = xor_q ^ b;
        end
      end
      last2_d = {last2_q[7:0], b};

      if (b == ngga_pkg::ChComma) begin
        if (commas_q < ngga_pkg::CommaMax) commas_d = commas_q + 4'd1;
        fstart_d = 1'b1;
      end else begin
        if (fstart_q) begin
          if (commas_q == ngga_pkg::FldNs && b == ngga_pkg::ChS) hemi_d[0] = 1'b1;
          if (commas_q == ngga_pkg::FldEw && b == ngga_pkg::ChW) hemi_d[1] = 1'b1;
        end
        fstart_d = 1'b0;
        if (b != ngga_pkg::ChDot && slot_hit) begin
          fv_d[slot] = slot_new;
        end
      end
      len_d = len_q + LenW'(1);
    end
  end

  // result next value
  always_comb begin
    res_valid_d = res_valid_q;
    taken_d     = taken_q;
    fix_d       = fix_q;
    lat_d       = lat_q;
    lon_d       = lon_q;
    dop_d       = dop_q;
    if (emit) begin
      res_valid_d = 1'b1;
      taken_d     = taken;
      fix_d       = valid;
      if (!taken) begin
        lat_d = '0;
        lon_d = '0;
        dop_d = '0;
      end else if (!valid) begin
        lat_d = ngga_pkg::NoFix;
        lon_d = ngga_pkg::NoFix;
        dop_d = ngga_pkg::DopMax;
      end else begin
        lat_d = fv_q[ngga_pkg::SlotLat] + (hemi_q[0] ? ngga_pkg::SignBit : 32'd0);
        lon_d = fv_q[ngga_pkg::SlotLon] + (hemi_q[1] ? ngga_pkg::SignBit : 32'd0);
        dop_d = (fv_q[ngga_pkg::SlotDop] > 32'd255) ? ngga_pkg::DopMax
                                                    : fv_q[ngga_pkg::SlotDop][7:0];
      end
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      start_ok_q  <= 1'b0;
      type_ok_q   <= 1'b0;
      xor_q       <= '0;
      star_q      <= 1'b0;
      star_pos_q  <= '0;
      last2_q     <= '0;
      commas_q    <= '0;
      fstart_q    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        fv_q[i] <= '0;
      end
      hemi_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      start_ok_q  <= start_ok_d;
      type_ok_q   <= type_ok_d;
      xor_q       <= xor_d;
      star_q      <= star_d;
      star_pos_q  <= star_pos_d;
      last2_q     <= last2_d;
      commas_q    <= commas_d;
      fstart_q    <= fstart_d;
      fv_q        <= fv_d;
      hemi_q      <= hemi_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    taken_q <= taken_d;
    fix_q   <= fix_d;
    lat_q   <= lat_d;
    lon_q   <= lon_d;
    dop_q   <= dop_d;
  end

  assign res_valid_o      = res_valid_q;
  assign sentence_taken_o = taken_q;
  assign fix_valid_o      = fix_q;
  assign latitude_o       = lat_q;
  assign longitude_o      = lon_q;
  assign dilution_o       = dop_q;

endmodule
